// ----- hw/rtl/lpufr_pkg.sv -----
// Shared types and constants for the length-prefixed UTF-8 frame receiver.
`default_nettype none

package lpufr_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int CP_W        = 21;

    typedef logic [1:0]             status_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_ZERO_LEN  = 2'd1;
    localparam status_t ST_TOO_LONG  = 2'd2;
    localparam status_t ST_BAD_UTF8  = 2'd3;

    localparam cfg_index_t CFG_MAX_LENGTH = 8'd0;
    localparam cfg_index_t CFG_CHECK_TEXT = 8'd1;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 32'd1048576;

    localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;

    localparam logic [CP_W-1:0] CP_MIN_LEAD2 = 21'h000002;
    localparam logic [CP_W-1:0] CP_MIN_3     = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_4     = 21'h010000;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

endpackage

`default_nettype wire

// ----- hw/rtl/length_prefixed_utf8_frame_receiver.sv -----
// Top level: length-prefixed frame receiver with on-the-fly UTF-8 checking.
//
//  channel | direction | handshake              | payload
//  s_      | in        | s_valid / s_ready      | s_in_byte
//  m_      | out       | m_valid / m_ready      | m_out_byte, m_frame_end, m_status
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle: each byte updates the header/length counters and the
// UTF-8 decoder in one pass, and any result lands in the output register the
// next cycle. s_ready drops only while the output register holds a result
// that m_ready does not take. Synchronous active-low reset clears all frame
// and decoder state and loads the configuration defaults; cfg_ready is always 1.
`default_nettype none

module length_prefixed_utf8_frame_receiver (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_in_byte,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_out_byte,
    output logic                                m_frame_end,
    output lpufr_pkg::status_t                  m_status,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire lpufr_pkg::cfg_index_t          cfg_index,
    input  wire logic [31:0]                    cfg_data
);
    import lpufr_pkg::*;

    logic [LEN_W-1:0]  max_length_reg;
    logic              check_text_reg;

    logic [1:0]        hdr_seen_reg, hdr_seen_next;
    logic [LEN_W-1:0]  frame_length_reg, frame_length_next;
    logic [LEN_W-1:0]  remaining_reg, remaining_next;
    logic [1:0]        cont_reg, cont_next;
    logic [1:0]        seq_len_reg, seq_len_next;
    logic [CP_W-1:0]   cp_reg, cp_next;
    logic              text_err_reg, text_err_next;

    logic              m_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              frame_end_reg;
    status_t           status_reg;

    logic              res_valid;
    logic [BYTE_W-1:0] res_byte;
    logic              res_end;
    status_t           res_status;

    logic              s_accept;
    logic [LEN_W-1:0]  len_asm;
    logic [CP_W-1:0]   cp_shift;
    logic [1:0]        cont_dec;
    logic [BYTE_W-1:0] c;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign c         = s_in_byte;
    assign cp_shift  = {cp_reg[CP_W-7:0], c[5:0]};
    assign cont_dec  = cont_reg - 2'd1;

    always_comb begin
        unique case (hdr_seen_reg)
            2'd0:    len_asm = {24'd0, c};
            2'd1:    len_asm = frame_length_reg | {16'd0, c, 8'd0};
            2'd2:    len_asm = frame_length_reg | {8'd0, c, 16'd0};
            default: len_asm = frame_length_reg | {c, 24'd0};
        endcase
    end

    always_comb begin
        hdr_seen_next     = hdr_seen_reg;
        frame_length_next = frame_length_reg;
        remaining_next    = remaining_reg;
        cont_next         = cont_reg;
        seq_len_next      = seq_len_reg;
        cp_next           = cp_reg;
        text_err_next     = text_err_reg;
        res_valid         = 1'b0;
        res_byte          = c;
        res_end           = 1'b0;
        res_status        = ST_OK;

        if (remaining_reg == '0) begin
            frame_length_next = len_asm;
            if (hdr_seen_reg != 2'd3) begin
                hdr_seen_next = hdr_seen_reg + 2'd1;
            end else begin
                hdr_seen_next = 2'd0;
                if (len_asm == '0) begin
                    res_valid  = 1'b1;
                    res_byte   = '0;
                    res_end    = 1'b1;
                    res_status = ST_ZERO_LEN;
                end else if (len_asm > max_length_reg) begin
                    res_valid  = 1'b1;
                    res_byte   = '0;
                    res_end    = 1'b1;
                    res_status = ST_TOO_LONG;
                end else begin
                    remaining_next = len_asm;
                    cont_next      = 2'd0;
                    seq_len_next   = 2'd0;
                    cp_next        = '0;
                    text_err_next  = 1'b0;
                end
            end
        end else begin
            if (check_text_reg && !text_err_reg) begin
                if (cont_reg == 2'd0) begin
                    if (c <= ASCII_MAX) begin
                        cont_next = 2'd0;
                    end else if ((c & LEAD2_MASK) == LEAD2_CODE) begin
                        cp_next = {16'd0, c[4:0]};
                        if ({16'd0, c[4:0]} < CP_MIN_LEAD2) begin
                            text_err_next = 1'b1;
                        end else begin
                            seq_len_next = 2'd1;
                            cont_next    = 2'd1;
                        end
                    end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
                        cp_next      = {17'd0, c[3:0]};
                        seq_len_next = 2'd2;
                        cont_next    = 2'd2;
                    end else if ((c & LEAD4_MASK) == LEAD4_CODE) begin
                        cp_next      = {18'd0, c[2:0]};
                        seq_len_next = 2'd3;
                        cont_next    = 2'd3;
                    end else begin
                        text_err_next = 1'b1;
                    end
                end else if ((c & CONT_MASK) != CONT_CODE) begin
                    text_err_next = 1'b1;
                end else begin
                    cont_next = cont_dec;
                    cp_next   = cp_shift;
                    if (cont_dec == 2'd0) begin
                        if ((seq_len_reg == 2'd2 && cp_shift < CP_MIN_3) ||
                            (seq_len_reg == 2'd3 && cp_shift < CP_MIN_4) ||
                            (cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI) ||
                            (cp_shift > CP_MAX)) begin
                            text_err_next = 1'b1;
                        end
                        seq_len_next = 2'd0;
                        cp_next      = '0;
                    end
                end
            end

            remaining_next = remaining_reg - 32'd1;
            res_valid      = 1'b1;
            if (remaining_reg == 32'd1) begin
                res_end = 1'b1;
                if (check_text_reg && (text_err_next || cont_next != 2'd0)) begin
                    res_status = ST_BAD_UTF8;
                end
                cont_next     = 2'd0;
                seq_len_next  = 2'd0;
                cp_next       = '0;
                text_err_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= MAX_LENGTH_RESET;
            check_text_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_MAX_LENGTH) begin
                max_length_reg <= cfg_data;
            end else if (cfg_index == CFG_CHECK_TEXT) begin
                check_text_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_seen_reg     <= 2'd0;
            frame_length_reg <= '0;
            remaining_reg    <= '0;
            cont_reg         <= 2'd0;
            seq_len_reg      <= 2'd0;
            cp_reg           <= '0;
            text_err_reg     <= 1'b0;
        end else if (s_accept) begin
            hdr_seen_reg     <= hdr_seen_next;
            frame_length_reg <= frame_length_next;
            remaining_reg    <= remaining_next;
            cont_reg         <= cont_next;
            seq_len_reg      <= seq_len_next;
            cp_reg           <= cp_next;
            text_err_reg     <= text_err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_accept && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            out_byte_reg  <= res_byte;
            frame_end_reg <= res_end;
            status_reg    <= res_status;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_frame_end = frame_end_reg;
    assign m_status    = status_reg;

`ifndef SYNTHESIS
    a_status_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_end |-> m_status == ST_OK)
        else $error("status set on a non-final item");

    a_header_err_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end && (m_status == ST_ZERO_LEN || m_status == ST_TOO_LONG)
        |-> m_out_byte == '0)
        else $error("header error item carries a nonzero byte");

    a_payload_gives_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && remaining_reg != '0 |=> m_valid)
        else $error("payload byte produced no item");

    a_decoder_idle_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        remaining_reg == '0 |-> cont_reg == 2'd0 && !text_err_reg)
        else $error("decoder state left open between frames");
`endif

endmodule

`default_nettype wire

// ----- test/tb_length_prefixed_utf8_frame_receiver.sv -----
// Testbench for the length-prefixed UTF-8 frame receiver: directed and random frames.
module tb_length_prefixed_utf8_frame_receiver;
    import lpufr_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam cfg_index_t  UNUSED_CFG_INDEX = 8'hA5;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        status_t    status;
    } frame_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_frame_end;
    status_t    m_status;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = CFG_MAX_LENGTH;
    logic [31:0] cfg_data = 32'd0;

    length_prefixed_utf8_frame_receiver i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_frame_end (m_frame_end),
        .m_status    (m_status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 aclk = ~aclk;

    // predictor state and its copy of the registers
    logic [31:0] model_max_len;
    logic        model_check_text;
    logic [2:0]  hdr_count;
    logic [31:0] len_acc;
    logic [31:0] left_count;
    logic [1:0]  cont_owed;
    logic [1:0]  seq_conts;
    logic [20:0] code_acc;
    logic        text_fault;

    frame_result_t expected_results[$];
    logic [7:0]    payload_q[$];

    // stimulus side view of the registers
    logic [31:0] cur_max = MAX_LENGTH_RESET;
    logic        cur_text = 1'b1;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic [7:0]  hold_token = 8'd0;
    logic [7:0]  hold_seen = 8'd0;
    int unsigned hold_left = 0;

    int unsigned bytes_sent = 0;
    int unsigned bytes_in = 0;
    int unsigned results_checked = 0;
    int unsigned frame_ends = 0;
    int unsigned header_rejects = 0;
    int unsigned cfg_writes = 0;
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;

    task automatic clear_utf8_state();
        cont_owed  = 2'd0;
        seq_conts  = 2'd0;
        code_acc   = 21'd0;
        text_fault = 1'b0;
    endtask

    task automatic decode_utf8_byte(input logic [7:0] c);
        if (text_fault)
            return;
        if (cont_owed == 2'd0) begin
            if (c <= ASCII_MAX)
                return;
            if ((c & LEAD2_MASK) == LEAD2_CODE) begin
                code_acc = {16'd0, c[4:0]};
                if (code_acc < CP_MIN_LEAD2) begin
                    text_fault = 1'b1;
                    return;
                end
                seq_conts = 2'd1;
            end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
                code_acc  = {17'd0, c[3:0]};
                seq_conts = 2'd2;
            end else if ((c & LEAD4_MASK) == LEAD4_CODE) begin
                code_acc  = {18'd0, c[2:0]};
                seq_conts = 2'd3;
            end else begin
                text_fault = 1'b1;
                return;
            end
            cont_owed = seq_conts;
            return;
        end
        if ((c & CONT_MASK) != CONT_CODE) begin
            text_fault = 1'b1;
            return;
        end
        code_acc  = {code_acc[14:0], c[5:0]};
        cont_owed = cont_owed - 2'd1;
        if (cont_owed != 2'd0)
            return;
        if (seq_conts == 2'd2 && code_acc < CP_MIN_3)
            text_fault = 1'b1;
        if (seq_conts == 2'd3 && code_acc < CP_MIN_4)
            text_fault = 1'b1;
        if (code_acc >= CP_SURR_LO && code_acc <= CP_SURR_HI)
            text_fault = 1'b1;
        if (code_acc > CP_MAX)
            text_fault = 1'b1;
        seq_conts = 2'd0;
        code_acc  = 21'd0;
    endtask

    task automatic predict_frame_byte(input logic [7:0] b);
        frame_result_t r;
        logic [1:0]    pos;
        if (left_count == 32'd0) begin
            pos = hdr_count[1:0];
            if (pos == 2'd0)
                len_acc = {24'd0, b};
            else
                len_acc = len_acc | ({24'd0, b} << (8 * pos));
            if (pos < 2'd3) begin
                hdr_count = pos + 3'd1;
                return;
            end
            hdr_count = 3'd0;
            if (len_acc == 32'd0 || len_acc > model_max_len) begin
                r.data   = 8'h00;
                r.last   = 1'b1;
                r.status = (len_acc == 32'd0) ? ST_ZERO_LEN : ST_TOO_LONG;
                expected_results.push_back(r);
                header_rejects++;
                return;
            end
            left_count = len_acc;
            clear_utf8_state();
            return;
        end
        if (model_check_text)
            decode_utf8_byte(b);
        left_count = left_count - 32'd1;
        r.data   = b;
        r.last   = (left_count == 32'd0);
        r.status = ST_OK;
        if (left_count == 32'd0) begin
            if (model_check_text && (text_fault || cont_owed != 2'd0))
                r.status = ST_BAD_UTF8;
            clear_utf8_state();
        end
        expected_results.push_back(r);
    endtask

    // predictor: follows every accepted item and register write
    always @(posedge aclk) begin
        if (!aresetn) begin
            model_max_len    = MAX_LENGTH_RESET;
            model_check_text = 1'b1;
            hdr_count        = 3'd0;
            len_acc          = 32'd0;
            left_count       = 32'd0;
            clear_utf8_state();
        end else begin
            if (s_valid && s_ready) begin
                bytes_in++;
                predict_frame_byte(s_in_byte);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MAX_LENGTH)
                    model_max_len = cfg_data;
                else if (cfg_index == CFG_CHECK_TEXT)
                    model_check_text = cfg_data[0];
            end
        end
    end

    always @(posedge aclk) begin : check_results
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: byte %02h end %0d status %0d",
                             m_out_byte, m_frame_end, m_status);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.last)
                    frame_ends++;
                if (want.data !== m_out_byte || want.last !== m_frame_end ||
                    want.status !== m_status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: expected byte %02h end %0d status %0d, ",
                                  "got byte %02h end %0d status %0d"},
                                 want.data, want.last, want.status,
                                 m_out_byte, m_frame_end, m_status);
                end
            end
        end
    end

    // result receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", stall_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [31:0] len);
        for (int k = 0; k < 4; k++)
            send_byte(len[8*k +: 8]);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_MAX_LENGTH)
            cur_max = value;
        else if (idx == CFG_CHECK_TEXT)
            cur_text = value[0];
        cfg_writes++;
    endtask

    task automatic push_encoded(input logic [20:0] cp, input int unsigned n);
        case (n)
            1: payload_q.push_back({1'b0, cp[6:0]});
            2: begin
                payload_q.push_back({3'b110, cp[10:6]});
                payload_q.push_back({2'b10, cp[5:0]});
            end
            3: begin
                payload_q.push_back({4'b1110, cp[15:12]});
                payload_q.push_back({2'b10, cp[11:6]});
                payload_q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                payload_q.push_back({5'b11110, cp[20:18]});
                payload_q.push_back({2'b10, cp[17:12]});
                payload_q.push_back({2'b10, cp[11:6]});
                payload_q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic push_utf8_char(input logic make_bad);
        logic [20:0] cp;
        logic [7:0]  ascii;
        if (!make_bad) begin
            case ($urandom_range(3))
                0: push_encoded(21'($urandom_range(21'h7F)), 1);
                1: push_encoded(21'($urandom_range(21'h80, 21'h7FF)), 2);
                2: begin
                    cp = 21'($urandom_range(21'h800, 21'hFFFF));
                    if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
                        cp = cp - 21'h800;
                    push_encoded(cp, 3);
                end
                default: push_encoded(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
            endcase
        end else begin
            case ($urandom_range(7))
                0: payload_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                1: payload_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
                2: push_encoded(21'($urandom_range(21'h7F)), 2);
                3: push_encoded(21'($urandom_range(21'h7FF)), 3);
                4: push_encoded(21'($urandom_range(21'hFFFF)), 4);
                5: push_encoded(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
                6: push_encoded(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
                default: begin
                    // three-byte lead and one continuation, then something other than a continuation
                    push_encoded(21'($urandom_range(21'h800, 21'hD7FF)), 3);
                    ascii = 8'($urandom_range(8'h7F));
                    payload_q[payload_q.size()-1] = ascii;
                end
            endcase
        end
    endtask

    task automatic send_frame(input logic [31:0] len, input int unsigned bad_pct);
        logic        noise;
        logic        make_bad;
        logic [7:0]  rnd;
        int unsigned fill;
        noise = ($urandom_range(99) < 10);
        send_header(len);
        if (len == 32'd0 || len > cur_max)
            return;
        payload_q.delete();
        while (payload_q.size() < len) begin
            if (noise || !cur_text) begin
                rnd = 8'($urandom);
                payload_q.push_back(rnd);
            end else begin
                fill = payload_q.size();
                make_bad = ($urandom_range(99) < bad_pct);
                push_utf8_char(make_bad);
                if (!make_bad && payload_q.size() > len) begin
                    while (payload_q.size() > fill)
                        void'(payload_q.pop_back());
                    rnd = 8'($urandom_range(8'h7F));
                    payload_q.push_back(rnd);
                end
            end
        end
        while (payload_q.size() > len)
            void'(payload_q.pop_back());
        foreach (payload_q[k])
            send_byte(payload_q[k]);
    endtask

    task automatic test_header_errors();
        send_header(32'd0);
        drain_results();
        write_reg(CFG_MAX_LENGTH, 32'd0);
        send_header(32'd1);
        send_header(32'hFFFF_FFFF);
    endtask

    task automatic test_text_faults();
        drain_results();
        write_reg(CFG_MAX_LENGTH, 32'hFFFF_FFFF);
        // C0 lead, then bytes that are no longer decoded
        send_header(32'd3);
        send_byte(8'hC0);
        send_byte(8'hAF);
        send_byte(8'h41);
        // three-byte sequence cut off at frame end
        send_header(32'd2);
        send_byte(8'hE2);
        send_byte(8'h82);
    endtask

    task automatic test_raw_mode();
        drain_results();
        write_reg(CFG_CHECK_TEXT, 32'hFFFF_FFFE);
        write_reg(UNUSED_CFG_INDEX, 32'd0);
        send_header(32'd1);
        send_byte(8'hFF);
    endtask

    task automatic test_mode_switch_midframe();
        drain_results();
        write_reg(CFG_CHECK_TEXT, 32'd1);
        send_header(32'd6);
        send_byte(8'hE2);
        send_byte(8'h82);
        drain_results();
        write_reg(CFG_CHECK_TEXT, 32'd0);
        send_byte(8'hFF);
        send_byte(8'h41);
        drain_results();
        write_reg(CFG_CHECK_TEXT, 32'd1);
        send_byte(8'hAC);
        send_byte(8'h41);
    endtask

    task automatic test_random_traffic(input logic [31:0] max_len, input logic text,
                                       input int unsigned n_bytes, input int unsigned bad_pct);
        int unsigned start;
        int unsigned pick;
        logic [31:0] len;
        logic [31:0] text_word;
        drain_results();
        write_reg(CFG_MAX_LENGTH, max_len);
        text_word = $urandom;
        text_word[0] = text;
        write_reg(CFG_CHECK_TEXT, text_word);
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 5)
                len = 32'd0;
            else if (pick < 10 && cur_max != 32'hFFFF_FFFF)
                len = cur_max + 32'd1;
            else if (pick < 16)
                len = $urandom;
            else
                len = $urandom_range(1, (cur_max == 32'd0 || cur_max > 32'd24) ? 24 : cur_max);
            if (len != 32'd0 && len <= cur_max && len > 32'd40)
                len = len % 40 + 1;
            send_frame(len, bad_pct);
        end
    endtask

    task automatic test_output_stall();
        int unsigned start;
        drain_results();
        hold_token <= hold_token + 8'd1;
        start = bytes_sent;
        while (bytes_sent - start < 120)
            send_frame($urandom_range(10, 40), 3);
    endtask

    initial begin
        send_idle_pct = 36;
        recv_idle_pct = 46;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_header_errors();
        test_text_faults();
        test_raw_mode();
        test_mode_switch_midframe();
        test_random_traffic(MAX_LENGTH_RESET, 1'b1, 550, 3);
        test_output_stall();

        send_idle_pct = 46;
        recv_idle_pct = 36;
        test_random_traffic($urandom_range(2, 30), 1'b1, 350, 4);
        test_random_traffic(32'd1, 1'b1, 200, 10);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(32'hFFFF_FFFF, 1'b0, 300, 0);
        test_random_traffic(32'hFFFF_FFFF, 1'b1, 350, 3);
        drain_results();

        $display("Summary: %0d bytes in, %0d results checked, %0d frame ends, %0d header rejects",
                 bytes_in, results_checked, frame_ends, header_rejects);
        $display("Summary: %0d register writes across text/raw modes and max lengths 0 to 2^32-1",
                 cfg_writes);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lpufr_pkg.sv
hw/rtl/length_prefixed_utf8_frame_receiver.sv
test/tb_length_prefixed_utf8_frame_receiver.sv
